[rtl/core/breakpoint_table_interpolator_macros.svh]
// assertion macros for the breakpoint table interpolator
// included by files that carry concurrent checks; needs nothing else
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_MACROS_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define BTI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BTI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/bti_pkg.sv]
// shared types, constants and helpers of the breakpoint table interpolator
// no dependencies
package bti_pkg;

   localparam int DATA_W     = 32;
   localparam int ENTRY_W    = 8;
   localparam int MAX_POINTS = 256;
   localparam int COUNT_W    = 9;
   localparam int MODE_W     = 4;
   localparam int WORK_W     = 48;   // working width of intermediates
   localparam int MAG_W      = 42;   // multiplier operand magnitude
   localparam int NUM_W      = 67;   // dividend magnitude
   localparam int DEN_W      = 33;   // divisor magnitude
   localparam int LIM_SHIFT  = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int STEP_W     = 4;

   localparam logic [WORK_W-1:0] LIM   = {{(WORK_W-LIM_SHIFT-1){1'b0}}, 1'b1,
                                          {LIM_SHIFT{1'b0}}};
   localparam logic [WORK_W-1:0] ONE_Q = WORK_W'(65536);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERP_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTRAPOLATE = 2'd2;

   // interpolation modes
   localparam logic [MODE_W-1:0] MODE_BELOW   = 4'd0;
   localparam logic [MODE_W-1:0] MODE_LINEAR  = 4'd1;
   localparam logic [MODE_W-1:0] MODE_QUAD    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_HERM_LO = 4'd3;
   localparam logic [MODE_W-1:0] MODE_HERM_HI = 4'd7;
   localparam logic [MODE_W-1:0] MODE_ABOVE   = 4'd8;
   localparam logic [MODE_W-1:0] MODE_NEAREST = 4'd9;

   // item opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                     op;
      logic [ENTRY_W-1:0]       entry_index;
      logic signed [DATA_W-1:0] point_x;
      logic signed [DATA_W-1:0] point_y;
      logic signed [DATA_W-1:0] coef_first;
      logic signed [DATA_W-1:0] coef_second;
      logic signed [DATA_W-1:0] coef_third;
      logic signed [DATA_W-1:0] query_x;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [ENTRY_W-1:0]       segment;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
   } row_type;

   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [WORK_W-1:0] value;
   } arith_res_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ENDS_LO, ST_ENDS_HI, ST_CLAMP_CHK, ST_SEG_LO, ST_SEG_HI, ST_SEG_CHK,
      ST_SRCH_ISSUE, ST_SRCH_CMP, ST_ROW_LO, ST_ROW_HI, ST_ROW_CAP, ST_DISPATCH,
      ST_ISSUE, ST_WAIT, ST_FINISH, ST_DONE
   } state_type;

   // magnitude of a two's complement working value
   function automatic logic [WORK_W-1:0] mag(input logic signed [WORK_W-1:0] v);
      logic [WORK_W-1:0] m;
      m = v[WORK_W-1] ? (~v + 1'b1) : v;
      return m;
   endfunction

endpackage

[rtl/core/bti_mem.sv]
// breakpoint table storage: one row per entry, one write and one read port
// depends on bti_pkg
module bti_mem import bti_pkg::*; (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ENTRY_W-1:0] wr_addr,
   input  row_type            wr_row,
   input  logic [ENTRY_W-1:0] rd_addr,
   output row_type            rd_row
);

   row_type mem [MAX_POINTS];
   row_type rd_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   assign rd_row = rd_ff;

endmodule

[rtl/core/bti_mul.sv]
// q16.16 multiplier, shift-accumulated in chunks of the second operand, magnitude truncation and clamp
// depends on bti_pkg
module bti_mul import bti_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WORK_W-1:0] a,
   input  logic signed [WORK_W-1:0] b,
   output arith_res_type            res,
   output logic [NUM_W-1:0]         raw
);

   localparam int STEPS   = 3;
   localparam int CHUNK_W = MAG_W / STEPS;
   localparam int ACC_W   = 2 * MAG_W;
   localparam int R_W     = ACC_W - 16;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [MAG_W-1:0]   ma_ff, ma_in, mb_ff, mb_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [MAG_W+CHUNK_W-1:0] prod;
   logic [WORK_W-1:0]  ma_full, mb_full;
   logic [R_W-1:0]     r;
   logic               sat;
   logic [WORK_W-1:0]  mv;

   assign ma_full = mag(a);
   assign mb_full = mag(b);
   assign prod    = ma_ff * mb_ff[MAG_W-1 -: CHUNK_W];

   // high chunk first, shift accumulate
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = a[WORK_W-1] ^ b[WORK_W-1];
         ma_in   = ma_full[MAG_W-1:0];
         mb_in   = mb_full[MAG_W-1:0];
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(prod);
         mb_in  = {mb_ff[MAG_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
   end

   // drop 16 fraction bits, clamp and restore sign
   assign r   = acc_ff[ACC_W-1:16];
   assign sat = r > R_W'(LIM);
   assign mv  = sat ? LIM : r[WORK_W-1:0];

   assign res.done  = done_ff;
   assign res.sat   = sat;
   assign res.value = neg_ff ? signed'(~mv + 1'b1) : signed'(mv);
   assign raw       = acc_ff[NUM_W-1:0];

endmodule

[rtl/core/bti_div.sv]
// restoring divider, one quotient bit per cycle, truncating and saturating
// depends on bti_pkg
module bti_div import bti_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NUM_W-1:0]         num,
   input  logic                     nneg,
   input  logic signed [WORK_W-1:0] den,
   output arith_res_type            res
);

   localparam int CNT_W = $clog2(NUM_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]   q_ff, q_in;
   logic [DEN_W:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]   dm_ff, dm_in;
   logic               neg_ff, neg_in;
   logic               zsat_ff, zsat_in;
   logic [WORK_W-1:0]  den_mag;
   logic [DEN_W:0]     rem_sh;
   logic               over;
   logic [WORK_W-1:0]  mv;

   assign den_mag = mag(den);
   assign rem_sh  = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dm_in   = dm_ff;
      neg_in  = neg_ff;
      zsat_in = zsat_ff;
      if (start) begin
         // zero divisor: zero over zero is zero, otherwise full scale
         if (den_mag == '0) begin
            done_in = 1'b1;
            q_in    = (num == '0) ? '0 : NUM_W'(LIM);
            zsat_in = num != '0;
            neg_in  = nneg;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            q_in    = num;
            rem_in  = '0;
            dm_in   = den_mag[DEN_W-1:0];
            neg_in  = nneg ^ den[WORK_W-1];
            zsat_in = 1'b0;
         end
      end else if (busy_ff) begin
         // one restoring step
         if (rem_sh >= {1'b0, dm_ff}) begin
            rem_in = rem_sh - {1'b0, dm_ff};
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dm_ff   <= dm_in;
      neg_ff  <= neg_in;
      zsat_ff <= zsat_in;
   end

   // clamp quotient and apply sign
   assign over = q_ff > NUM_W'(LIM);
   assign mv   = over ? LIM : q_ff[WORK_W-1:0];

   assign res.done  = done_ff;
   assign res.sat   = over | zsat_ff;
   assign res.value = neg_ff ? signed'(~mv + 1'b1) : signed'(mv);

endmodule

[rtl/core/breakpoint_table_interpolator.sv]
// breakpoint_table_interpolator: users see a req/rsp item channel plus a csr write port.
// A load item (op 0) writes one table row (x, y and three coefficients) and
// returns an all-zero result. A query item (op 1) reads both table ends, checks
// the remembered segment, bisects if needed (up to 8 probes), then evaluates on
// one shared multiplier and one shared divider: the 67-step restoring divide and
// the three-step multiplier, reused for every product. One item is in flight at
// a time, so a new item is accepted only after the previous one leaves the sequencer.
// req_ready is high only while the sequencer is idle. A finished result sits in
// an output register; the next item is accepted while it waits, and the
// sequencer holds its own result until rsp_ready frees the register.
// Reset (synchronous, active high) sets point_count 2, interp_mode linear,
// extrapolate off, and clears the cached segment and last output. Table rows are
// undefined until loaded. csr writes are always ready and are meant for idle time.
// depends on bti_pkg, bti_mem, bti_mul, bti_div and the assertion macro header
`include "breakpoint_table_interpolator_macros.svh"

module breakpoint_table_interpolator import bti_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // clamp to the intermediate bound, sat flag on top
   function automatic logic [WORK_W:0] clamp_lim(input logic signed [WORK_W-1:0] v);
      logic signed [WORK_W-1:0] lim_s;
      lim_s = signed'(LIM);
      if (v > lim_s) return {1'b1, LIM};
      if (v < -lim_s) return {1'b1, ~LIM + 1'b1};
      return {1'b0, v};
   endfunction

   // control state
   state_type             state_ff, state_in;
   logic [ENTRY_W-1:0]    cache_ff, cache_in;
   logic signed [DATA_W-1:0] last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic                  extrap_ff;

   // datapath
   logic signed [DATA_W-1:0] u_ff, u_in, x0_ff, x0_in, y0_ff, y0_in;
   logic signed [DATA_W-1:0] xl_ff, xl_in, xi_ff, xi_in;
   logic signed [DATA_W-1:0] x2_ff, x2_in, y2_ff, y2_in, a2_ff, a2_in;
   row_type               r1_ff, r1_in;
   logic [ENTRY_W-1:0]    seg_ff, seg_in, lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic signed [WORK_W-1:0] p_ff, p_in, s_ff, s_in, s2_ff, s2_in, acc_ff, acc_in;
   logic signed [WORK_W-1:0] h00_ff, h00_in, h10_ff, h10_in, h01_ff, h01_in;
   logic signed [WORK_W-1:0] h11_ff, h11_in;
   logic                  sat_ff, sat_in;
   rsp_type               res_ff, res_in, rsp_ff, rsp_in;

   // memory and shared units
   logic                  mem_wr;
   row_type               wr_row, rd_row;
   logic [ENTRY_W-1:0]    rd_addr;
   logic                  mul_start, div_start;
   arith_res_type         mul_res, div_res, unit_res;
   logic [NUM_W-1:0]      mul_raw;

   // operand selection
   logic                  op_div;
   logic signed [WORK_W-1:0] op_a, op_b;
   logic [NUM_W-1:0]      op_num;
   logic                  op_nneg;
   logic                  last_step;

   // derived values
   logic [COUNT_W-1:0]    n;
   logic [ENTRY_W-1:0]    n_last, n_prev, i0, mid;
   logic                  accept, is_lin, is_quad, is_herm, mode_zero, clamp_en;
   logic signed [DATA_W:0]   dy, du, dt;
   logic [DATA_W:0]       du_mag;
   logic signed [DATA_W+1:0] u2, xsum;
   logic signed [WORK_W-1:0] dy_w, du_w, dt_w, y1_w, y2_w, s3;
   logic [WORK_W:0]       h00_c, h10_c, h01_c, h11_c, y_c;
   logic signed [WORK_W-1:0] out_max, out_min;
   logic signed [DATA_W-1:0] y_out;
   logic                  y_sat;

   assign accept    = req_valid & req_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // effective point count and table bounds
   always_comb begin
      if (count_ff < COUNT_W'(2)) n = COUNT_W'(2);
      else if (count_ff > COUNT_W'(MAX_POINTS)) n = COUNT_W'(MAX_POINTS);
      else n = count_ff;
   end
   assign n_last = ENTRY_W'(n - COUNT_W'(1));
   assign n_prev = ENTRY_W'(n - COUNT_W'(2));
   assign i0     = (cache_ff > n_prev) ? n_prev : cache_ff;
   assign mid    = ENTRY_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);

   // mode decode
   assign is_lin    = mode_ff == MODE_LINEAR;
   assign is_quad   = mode_ff == MODE_QUAD;
   assign is_herm   = (mode_ff >= MODE_HERM_LO) && (mode_ff <= MODE_HERM_HI);
   assign mode_zero = (mode_ff == MODE_BELOW) || (mode_ff == MODE_ABOVE) ||
                      (mode_ff == MODE_NEAREST);
   assign clamp_en  = !extrap_ff || mode_zero;

   // segment differences
   assign dy     = (DATA_W+1)'(y2_ff) - (DATA_W+1)'(r1_ff.y);
   assign du     = (DATA_W+1)'(u_ff) - (DATA_W+1)'(r1_ff.x);
   assign dt     = (DATA_W+1)'(x2_ff) - (DATA_W+1)'(r1_ff.x);
   assign du_mag = du[DATA_W] ? (~du + 1'b1) : du;
   assign u2     = {u_ff[DATA_W-1], u_ff, 1'b0};
   assign xsum   = (DATA_W+2)'(r1_ff.x) + (DATA_W+2)'(x2_ff);
   assign dy_w   = WORK_W'(dy);
   assign du_w   = WORK_W'(du);
   assign dt_w   = WORK_W'(dt);
   assign y1_w   = WORK_W'(r1_ff.y);
   assign y2_w   = WORK_W'(y2_ff);

   // hermite basis from s, s^2 and the fresh s^3
   assign s3    = unit_res.value;
   assign h00_c = clamp_lim((s3 <<< 1) - ((s2_ff <<< 1) + s2_ff) + signed'(ONE_Q));
   assign h10_c = clamp_lim(s3 - (s2_ff <<< 1) + s_ff);
   assign h01_c = clamp_lim(((s2_ff <<< 1) + s2_ff) - (s3 <<< 1));
   assign h11_c = clamp_lim(s3 - s2_ff);

   // final clamp to the output range
   assign out_max = WORK_W'({1'b0, {(DATA_W-1){1'b1}}});
   assign out_min = ~out_max;
   always_comb begin
      y_sat = 1'b0;
      y_out = acc_ff[DATA_W-1:0];
      if (acc_ff > out_max) begin
         y_sat = 1'b1;
         y_out = out_max[DATA_W-1:0];
      end else if (acc_ff < out_min) begin
         y_sat = 1'b1;
         y_out = out_min[DATA_W-1:0];
      end
   end
   assign y_c = {y_sat, WORK_W'(y_out)};

   // operands for the current arithmetic step
   always_comb begin
      op_div    = 1'b0;
      op_a      = '0;
      op_b      = '0;
      op_num    = '0;
      op_nneg   = 1'b0;
      last_step = 1'b0;
      if (is_lin) begin
         op_a      = dy_w;
         op_b      = du_w;
         op_num    = num_ff;
         op_nneg   = dy[DATA_W] ^ du[DATA_W];
         op_div    = step_ff != '0;
         last_step = step_ff != '0;
      end else if (is_quad) begin
         op_b      = du_w;
         last_step = step_ff == STEP_W'(2);
         unique case (step_ff)
            STEP_W'(0): op_a = WORK_W'(r1_ff.a);
            STEP_W'(1): op_a = p_ff;
            default:    op_a = WORK_W'(r1_ff.b);
         endcase
      end else begin
         op_num    = NUM_W'({du_mag, 16'b0});
         op_nneg   = du[DATA_W];
         last_step = step_ff == STEP_W'(8);
         unique case (step_ff)
            STEP_W'(0): op_div = 1'b1;
            STEP_W'(1): begin op_a = s_ff;   op_b = s_ff;  end
            STEP_W'(2): begin op_a = s2_ff;  op_b = s_ff;  end
            STEP_W'(3): begin op_a = h00_ff; op_b = y1_w;  end
            STEP_W'(4): begin op_a = h10_ff; op_b = dt_w;  end
            STEP_W'(5): begin op_a = p_ff;   op_b = WORK_W'(r1_ff.a); end
            STEP_W'(6): begin op_a = h01_ff; op_b = y2_w;  end
            STEP_W'(7): begin op_a = h11_ff; op_b = dt_w;  end
            default:    begin op_a = p_ff;   op_b = WORK_W'(a2_ff); end
         endcase
      end
   end

   assign unit_res = div_res.done ? div_res : mul_res;

   // sequencer: next state, memory address and datapath updates
   always_comb begin
      state_in     = state_ff;
      cache_in     = cache_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      u_in   = u_ff;   x0_in = x0_ff; y0_in = y0_ff; xl_in = xl_ff; xi_in = xi_ff;
      x2_in  = x2_ff;  y2_in = y2_ff; a2_in = a2_ff; r1_in = r1_ff;
      seg_in = seg_ff; lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff;
      step_in = step_ff; num_in = num_ff; p_in = p_ff; s_in = s_ff; s2_in = s2_ff;
      acc_in = acc_ff; h00_in = h00_ff; h10_in = h10_ff; h01_in = h01_ff;
      h11_in = h11_ff; sat_in = sat_ff; res_in = res_ff;
      rd_addr   = '0;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_LOAD) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  u_in     = req_data.query_x;
                  sat_in   = 1'b0;
                  state_in = ST_ENDS_LO;
               end
            end
         end
         ST_ENDS_LO: begin
            rd_addr  = '0;
            state_in = ST_ENDS_HI;
         end
         ST_ENDS_HI: begin
            rd_addr  = n_last;
            x0_in    = rd_row.x;
            y0_in    = rd_row.y;
            state_in = ST_CLAMP_CHK;
         end
         ST_CLAMP_CHK: begin
            // outside the table with clamping: end value, cache untouched
            xl_in = rd_row.x;
            if (clamp_en && (u_ff < x0_ff)) begin
               res_in   = '{result_value: y0_ff, segment: '0, saturated: 1'b0};
               last_in  = y0_ff;
               state_in = ST_DONE;
            end else if (clamp_en && (u_ff >= rd_row.x)) begin
               res_in   = '{result_value: rd_row.y, segment: n_prev, saturated: 1'b0};
               last_in  = rd_row.y;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SEG_LO;
            end
         end
         ST_SEG_LO: begin
            rd_addr  = i0;
            state_in = ST_SEG_HI;
         end
         ST_SEG_HI: begin
            rd_addr  = ENTRY_W'(i0 + 1'b1);
            xi_in    = rd_row.x;
            state_in = ST_SEG_CHK;
         end
         ST_SEG_CHK: begin
            // cached segment hit, or search below or above it; a query at or past an end takes that end's segment
            if ((u_ff < xi_ff) || (u_ff >= rd_row.x)) begin
               if (u_ff < xi_ff) begin
                  lo_in = '0;
                  hi_in = i0;
               end else begin
                  lo_in = ENTRY_W'(i0 + 1'b1);
                  hi_in = n_last;
               end
               if (u_ff <= x0_ff) begin
                  seg_in   = '0;
                  state_in = ST_ROW_LO;
               end else if (u_ff >= xl_ff) begin
                  seg_in   = n_prev;
                  state_in = ST_ROW_LO;
               end else begin
                  state_in = ST_SRCH_ISSUE;
               end
            end else begin
               seg_in   = i0;
               state_in = ST_ROW_LO;
            end
         end
         ST_SRCH_ISSUE: begin
            if (({1'b0, lo_ff} + 1'b1) < {1'b0, hi_ff}) begin
               rd_addr  = mid;
               mid_in   = mid;
               state_in = ST_SRCH_CMP;
            end else begin
               seg_in   = lo_ff;
               state_in = ST_ROW_LO;
            end
         end
         ST_SRCH_CMP: begin
            if (u_ff >= rd_row.x) lo_in = mid_ff;
            else hi_in = mid_ff;
            state_in = ST_SRCH_ISSUE;
         end
         ST_ROW_LO: begin
            rd_addr  = seg_ff;
            cache_in = seg_ff;
            state_in = ST_ROW_HI;
         end
         ST_ROW_HI: begin
            rd_addr  = ENTRY_W'(seg_ff + 1'b1);
            r1_in    = rd_row;
            state_in = ST_ROW_CAP;
         end
         ST_ROW_CAP: begin
            x2_in    = rd_row.x;
            y2_in    = rd_row.y;
            a2_in    = rd_row.a;
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            step_in = '0;
            if (mode_ff == MODE_BELOW) begin
               acc_in   = y1_w;
               state_in = ST_FINISH;
            end else if (mode_ff == MODE_ABOVE) begin
               acc_in   = y2_w;
               state_in = ST_FINISH;
            end else if (mode_ff == MODE_NEAREST) begin
               acc_in   = (u2 < xsum) ? y1_w : y2_w;
               state_in = ST_FINISH;
            end else if (is_lin || is_herm || (is_quad && (n > COUNT_W'(2)))) begin
               state_in = ST_ISSUE;
            end else begin
               // quadratic on two points and unused modes hold the last output
               acc_in   = WORK_W'(last_ff);
               state_in = ST_FINISH;
            end
         end
         ST_ISSUE: begin
            mul_start = !op_div;
            div_start = op_div;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_res.done) begin
               // the exact linear product feeds the divider and never clamps
               sat_in  = sat_ff | (unit_res.sat & !(is_lin && (step_ff == '0)));
               step_in = step_ff + 1'b1;
               if (is_lin) begin
                  if (step_ff == '0) num_in = mul_raw;
                  else acc_in = unit_res.value + y1_w;
               end else if (is_quad) begin
                  if (step_ff == STEP_W'(2)) acc_in = p_ff + unit_res.value + WORK_W'(r1_ff.c);
                  else p_in = unit_res.value;
               end else begin
                  unique case (step_ff)
                     STEP_W'(0): s_in = unit_res.value;
                     STEP_W'(1): s2_in = unit_res.value;
                     STEP_W'(2): begin
                        h00_in = h00_c[WORK_W-1:0];
                        h10_in = h10_c[WORK_W-1:0];
                        h01_in = h01_c[WORK_W-1:0];
                        h11_in = h11_c[WORK_W-1:0];
                        sat_in = sat_ff | unit_res.sat | h00_c[WORK_W] | h10_c[WORK_W] |
                                 h01_c[WORK_W] | h11_c[WORK_W];
                     end
                     STEP_W'(3): acc_in = unit_res.value;
                     STEP_W'(4), STEP_W'(7): p_in = unit_res.value;
                     default: acc_in = acc_ff + unit_res.value;
                  endcase
               end
               state_in = last_step ? ST_FINISH : ST_ISSUE;
            end
         end
         ST_FINISH: begin
            res_in   = '{result_value: y_out, segment: seg_ff,
                         saturated: sat_ff | y_c[WORK_W]};
            last_in  = y_out;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cache_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_W'(2);
         mode_ff      <= MODE_LINEAR;
         extrap_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cache_ff     <= cache_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POINT_COUNT) count_ff <= csr_data;
            else if (csr_index == CSR_INTERP_MODE) mode_ff <= csr_data[MODE_W-1:0];
            else if (csr_index == CSR_EXTRAPOLATE) extrap_ff <= csr_data[0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      u_ff <= u_in;  x0_ff <= x0_in; y0_ff <= y0_in; xl_ff <= xl_in; xi_ff <= xi_in;
      x2_ff <= x2_in; y2_ff <= y2_in; a2_ff <= a2_in; r1_ff <= r1_in;
      seg_ff <= seg_in; lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in;
      step_ff <= step_in; num_ff <= num_in; p_ff <= p_in; s_ff <= s_in;
      s2_ff <= s2_in; acc_ff <= acc_in; h00_ff <= h00_in; h10_ff <= h10_in;
      h01_ff <= h01_in; h11_ff <= h11_in; sat_ff <= sat_in; res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   // table write on load items
   assign mem_wr = accept && (req_data.op == OP_LOAD);
   assign wr_row = '{x: req_data.point_x, y: req_data.point_y, a: req_data.coef_first,
                     b: req_data.coef_second, c: req_data.coef_third};

   bti_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (req_data.entry_index),
      .wr_row  (wr_row),
      .rd_addr (rd_addr),
      .rd_row  (rd_row)
   );

   bti_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (op_a),
      .b     (op_b),
      .res   (mul_res),
      .raw   (mul_raw)
   );

   bti_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (op_num),
      .nneg  (op_nneg),
      .den   (dt_w),
      .res   (div_res)
   );

   // checks
   `BTI_ASSERT_IMP(a_seg_in_table, clock, reset, state_ff == ST_FINISH, seg_ff <= n_prev, "segment beyond table")
   `BTI_ASSERT_IMP(a_one_unit_done, clock, reset, mul_res.done, !div_res.done, "both units finished together")
   `BTI_ASSERT_NXT(a_leave_idle, clock, reset, accept, state_ff != ST_IDLE, "sequencer stayed idle after item")

endmodule
